[src/rlu_pkg.sv]
// Shared types, constants and helpers of the radial lens undistortion block.
// No dependencies; all other files but rlu_div_cell refer to this package by scoped names.
package rlu_pkg;

    localparam int ITERATIONS_DEF = 20;
    localparam int CFG_W          = 20;
    localparam int PIX_W          = 24;
    localparam int NORM_W         = 23;
    localparam int QUO_W          = 23;
    localparam int FRAC           = 20;
    localparam int NORM_AW        = 45;
    localparam int NORM_DW        = 20;
    localparam int ITER_AW        = 43;
    localparam int ITER_DW        = 36;

    typedef logic signed [NORM_W-1:0] norm_t;
    typedef logic signed [PIX_W-1:0]  pix_t;

    localparam norm_t NORM_MAX = norm_t'(23'sd4194303);
    localparam norm_t NORM_MIN = norm_t'(-23'sd4194304);

    typedef enum logic [2:0] {
        REG_FOCAL_X  = 3'd0,
        REG_FOCAL_Y  = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_K1       = 3'd4,
        REG_K2       = 3'd5
    } cfg_index_t;

    // Point as it travels between iterations.
    typedef struct packed {
        norm_t xn;
        norm_t yn;
        norm_t x;
        norm_t y;
        logic  degen;
        logic  last;
    } iter_state_t;

    typedef struct packed {
        logic       last;
        logic [1:0] neg;
        logic [1:0] ovf;
        logic [1:0] zero;
    } norm_side_t;

    typedef struct packed {
        iter_state_t st;
        logic        hit;
        logic [1:0]  neg;
        logic [1:0]  ovf;
    } iter_side_t;

    // Apply sign and saturate an unsigned rounded quotient to Q2.20.
    function automatic norm_t div_sat(logic [QUO_W-1:0] q, logic ovf, logic neg, logic zero);
        norm_t r;
        if (zero)
            r = '0;
        else if (!neg)
            r = (ovf || q > 23'd4194303) ? NORM_MAX : norm_t'(q);
        else
            r = (ovf || q > 23'd4194304) ? NORM_MIN : norm_t'(23'd0 - q);
        return r;
    endfunction

endpackage

[src/rlu_point_if.sv]
// Input channel of the undistortion block: one distorted point per request.
// Depends on rlu_pkg for the coordinate type.
interface rlu_point_if;
    logic          valid;
    logic          ready;
    rlu_pkg::pix_t pix_u;
    rlu_pkg::pix_t pix_v;
    logic          last_in;

    modport source (output valid, output pix_u, output pix_v, output last_in, input ready);
    modport sink (input valid, input pix_u, input pix_v, input last_in, output ready);
endinterface

[src/rlu_result_if.sv]
// Output channel of the undistortion block: one undistorted point per request.
// Depends on rlu_pkg for the coordinate type.
interface rlu_result_if;
    logic          valid;
    logic          ready;
    rlu_pkg::pix_t und_u;
    rlu_pkg::pix_t und_v;
    logic          degenerate;
    logic          last_out;

    modport source (output valid, output und_u, output und_v, output degenerate,
                    output last_out, input ready);
    modport sink (input valid, input und_u, input und_v, input degenerate,
                  input last_out, output ready);
endinterface

[src/rlu_div_cell.sv]
// One restoring-division cell for two lanes: produces one quotient bit per lane.
// Depends on rlu_pkg only through the side type handed in by the parent.
module rlu_div_cell #(
    parameter int  DW  = 20,
    parameter int  AW  = 45,
    parameter int  QW  = 23,
    parameter int  BIT = 0,
    parameter type side_t = logic
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   valid_i,
    input  side_t                  side_i,
    input  logic [1:0][AW-1:0]     num_i,
    input  logic [1:0][DW-1:0]     den_i,
    input  logic [1:0][DW-1:0]     rem_i,
    input  logic [1:0][QW-1:0]     quo_i,
    output logic                   valid_o,
    output side_t                  side_o,
    output logic [1:0][AW-1:0]     num_o,
    output logic [1:0][DW-1:0]     den_o,
    output logic [1:0][DW-1:0]     rem_o,
    output logic [1:0][QW-1:0]     quo_o
);

    logic               valid_reg;
    side_t              side_reg;
    logic [1:0][AW-1:0] num_reg;
    logic [1:0][DW-1:0] den_reg;
    logic [1:0][DW-1:0] rem_reg;
    logic [1:0][DW-1:0] rem_next;
    logic [1:0][QW-1:0] quo_reg;
    logic [1:0][QW-1:0] quo_next;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [DW:0] r;
            logic        ge;
            r  = {rem_i[l], num_i[l][BIT]};
            ge = (r >= {1'b0, den_i[l]});
            rem_next[l] = ge ? DW'(r - {1'b0, den_i[l]}) : r[DW-1:0];
            quo_next[l] = quo_i[l] | (QW'(ge) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_i;
            num_reg  <= num_i;
            den_reg  <= den_i;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign valid_o = valid_reg;
    assign side_o  = side_reg;
    assign num_o   = num_reg;
    assign den_o   = den_reg;
    assign rem_o   = rem_reg;
    assign quo_o   = quo_reg;

endmodule

[src/rlu_iter.sv]
// One fixed-point iteration x = xn / (1 + r2*(k1 + r2*k2)) as a pipeline slice.
// Depends on rlu_pkg and rlu_div_cell.
module rlu_iter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic signed [19:0]   k1,
    input  logic signed [19:0]   k2,
    input  logic                 valid_i,
    input  rlu_pkg::iter_state_t st_i,
    output logic                 valid_o,
    output rlu_pkg::iter_state_t st_o
);

    localparam int DW = rlu_pkg::ITER_DW;
    localparam int AW = rlu_pkg::ITER_AW;
    localparam int QW = rlu_pkg::QUO_W;

    // radial factor stages
    logic [5:0]            v_reg;
    rlu_pkg::iter_state_t  st1_reg, st2_reg, st3_reg, st4_reg, st5_reg, st6_reg;
    logic [44:0]           sqx1_reg, sqy1_reg;
    logic [25:0]           r2_2_reg, r2_3_reg, r2_4_reg;
    logic signed [46:0]    p3_reg;
    logic signed [30:0]    inner4_reg;
    logic signed [57:0]    q5_reg;
    logic signed [37:0]    rad6_reg;

    logic signed [45:0]    px_sq, py_sq;
    logic [45:0]           sum_sq;
    logic signed [46:0]    p_next;
    logic signed [30:0]    inner_next;
    logic signed [57:0]    q_next;
    logic signed [37:0]    rad_next;

    always_comb
    begin
        logic [46:0] pm;
        logic [30:0] pa;
        logic [57:0] qm;
        logic [37:0] qa;
        px_sq  = st_i.x * st_i.x;
        py_sq  = st_i.y * st_i.y;
        sum_sq = {1'b0, sqx1_reg} + {1'b0, sqy1_reg} + 46'd524288;
        p_next = $signed({1'b0, r2_2_reg}) * k2;
        pm = p3_reg[46] ? 47'(-p3_reg) : 47'(p3_reg);
        pa = 31'((pm + 47'd32768) >> 16);
        inner_next = {{7{k1[19]}}, k1, 4'b0000} + (p3_reg[46] ? -$signed(pa) : $signed(pa));
        q_next = $signed({1'b0, r2_4_reg}) * inner4_reg;
        qm = q5_reg[57] ? 58'(-q5_reg) : 58'(q5_reg);
        qa = 38'((qm + 58'd524288) >> 20);
        rad_next = 38'sd1048576 + (q5_reg[57] ? -$signed(qa) : $signed(qa));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[4:0], valid_i};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg    <= st_i;
            sqx1_reg   <= px_sq[44:0];
            sqy1_reg   <= py_sq[44:0];
            st2_reg    <= st1_reg;
            r2_2_reg   <= sum_sq[45:20];
            st3_reg    <= st2_reg;
            r2_3_reg   <= r2_2_reg;
            p3_reg     <= p_next;
            st4_reg    <= st3_reg;
            r2_4_reg   <= r2_3_reg;
            inner4_reg <= inner_next;
            st5_reg    <= st4_reg;
            q5_reg     <= q_next;
            st6_reg    <= st5_reg;
            rad6_reg   <= rad_next;
        end
    end

    // set up both lanes of the divider from the radial factor
    rlu_pkg::iter_side_t  side7_next;
    logic [1:0][AW-1:0]   num7_next;
    logic [1:0][DW-1:0]   den7_next;
    logic [1:0][DW-1:0]   rem7_next;

    always_comb
    begin
        logic [37:0]          ar;
        logic [DW-1:0]        d;
        rlu_pkg::norm_t       n [2];
        logic [AW-1:0]        a;
        logic [19:0]          hi;
        ar = rad6_reg[37] ? 38'(-rad6_reg) : 38'(rad6_reg);
        d  = ar[DW-1:0];
        n[0] = st6_reg.xn;
        n[1] = st6_reg.yn;
        side7_next.st  = st6_reg;
        side7_next.hit = (ar <= 38'd1);
        for (int l = 0; l < 2; l++)
        begin
            logic [22:0] m;
            m  = n[l][22] ? 23'(-n[l]) : 23'(n[l]);
            a  = {m, 20'b0} + AW'(ar >> 1);
            hi = a[AW-1:QW];
            num7_next[l] = a;
            den7_next[l] = d;
            rem7_next[l] = DW'(hi);
            side7_next.neg[l] = n[l][22] ^ rad6_reg[37];
            side7_next.ovf[l] = (DW'(hi) >= d);
        end
    end

    logic                  vc   [QW+1];
    rlu_pkg::iter_side_t   sc   [QW+1];
    logic [1:0][AW-1:0]    nc   [QW+1];
    logic [1:0][DW-1:0]    dc   [QW+1];
    logic [1:0][DW-1:0]    rc   [QW+1];
    logic [1:0][QW-1:0]    qc   [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc[0] <= 1'b0;
        else if (en)
            vc[0] <= v_reg[5];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc[0] <= side7_next;
            nc[0] <= num7_next;
            dc[0] <= den7_next;
            rc[0] <= rem7_next;
        end
    end

    assign qc[0] = '0;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        rlu_div_cell #(
            .DW(DW), .AW(AW), .QW(QW), .BIT(QW - 1 - k), .side_t(rlu_pkg::iter_side_t)
        ) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_i(vc[k]), .side_i(sc[k]), .num_i(nc[k]), .den_i(dc[k]),
            .rem_i(rc[k]), .quo_i(qc[k]),
            .valid_o(vc[k+1]), .side_o(sc[k+1]), .num_o(nc[k+1]), .den_o(dc[k+1]),
            .rem_o(rc[k+1]), .quo_o(qc[k+1])
        );
    end

    // freeze on a degenerate factor, otherwise take the new quotients
    logic                 vo_reg;
    rlu_pkg::iter_state_t st_reg;
    rlu_pkg::iter_state_t st_next;

    always_comb
    begin
        rlu_pkg::iter_side_t s;
        s = sc[QW];
        st_next = s.st;
        if (!s.st.degen)
        begin
            if (s.hit)
                st_next.degen = 1'b1;
            else
            begin
                st_next.x = rlu_pkg::div_sat(qc[QW][0], s.ovf[0], s.neg[0], 1'b0);
                st_next.y = rlu_pkg::div_sat(qc[QW][1], s.ovf[1], s.neg[1], 1'b0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= vc[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

    assign valid_o = vo_reg;
    assign st_o    = st_reg;

endmodule

[src/radial_lens_undistort_point.sv]
// Radial lens undistortion of one point per cycle: fully pipelined chain of cells.
// It holds one 23-cell divider per normalize step and per iteration. Throughput: one
// point per cycle; a stalled output holds the whole pipeline. Reset: rst_n clears all
// valid bits and loads register defaults.
// Depends on rlu_pkg, rlu_point_if, rlu_result_if, rlu_div_cell and rlu_iter.
module radial_lens_undistort_point #(
    parameter int ITERATIONS = rlu_pkg::ITERATIONS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rlu_point_if.sink                  point,
    rlu_result_if.source               result,
    input  logic                       write_en,
    input  logic [2:0]                 write_index,
    input  logic [rlu_pkg::CFG_W-1:0]  write_data
);

    localparam int DW = rlu_pkg::NORM_DW;
    localparam int AW = rlu_pkg::NORM_AW;
    localparam int QW = rlu_pkg::QUO_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [19:0]        focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic signed [19:0] k1_reg, k2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= 20'd262144;
            focal_y_reg  <= 20'd262144;
            center_x_reg <= 20'd245760;
            center_y_reg <= 20'd138240;
            k1_reg       <= '0;
            k2_reg       <= '0;
        end
        else if (write_en)
        begin
            unique case (rlu_pkg::cfg_index_t'(write_index))
                rlu_pkg::REG_FOCAL_X:  focal_x_reg  <= write_data;
                rlu_pkg::REG_FOCAL_Y:  focal_y_reg  <= write_data;
                rlu_pkg::REG_CENTER_X: center_x_reg <= write_data;
                rlu_pkg::REG_CENTER_Y: center_y_reg <= write_data;
                rlu_pkg::REG_K1:       k1_reg       <= $signed(write_data);
                rlu_pkg::REG_K2:       k2_reg       <= $signed(write_data);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Global advance: the pipeline moves whenever the output register
    // is empty or its request is being taken this cycle.
    // ---------------------------------------------------------------
    logic en;
    logic out_valid_reg;

    assign en          = !out_valid_reg || result.ready;
    assign point.ready = en;

    // ---------------------------------------------------------------
    // Normalize: (pix - center) << 20 / focal, rounded, saturated
    // ---------------------------------------------------------------
    rlu_pkg::norm_side_t  nside_next;
    logic [1:0][AW-1:0]   nnum_next;
    logic [1:0][DW-1:0]   nden_next;
    logic [1:0][DW-1:0]   nrem_next;

    always_comb
    begin
        logic signed [24:0] num [2];
        logic [19:0]        f   [2];
        logic [24:0]        m;
        logic [AW-1:0]      a;
        logic [21:0]        hi;
        num[0] = {point.pix_u[23], point.pix_u} - $signed({5'b0, center_x_reg});
        num[1] = {point.pix_v[23], point.pix_v} - $signed({5'b0, center_y_reg});
        f[0]   = focal_x_reg;
        f[1]   = focal_y_reg;
        nside_next.last = point.last_in;
        for (int l = 0; l < 2; l++)
        begin
            m  = num[l][24] ? 25'(-num[l]) : 25'(num[l]);
            a  = {1'b0, m[23:0], 20'b0} + AW'(f[l] >> 1);
            hi = a[AW-1:QW];
            nnum_next[l] = a;
            nden_next[l] = f[l];
            nrem_next[l] = hi[DW-1:0];
            nside_next.neg[l]  = num[l][24];
            nside_next.zero[l] = (num[l] == 25'sd0);
            nside_next.ovf[l]  = (hi >= {2'b00, f[l]});
        end
    end

    logic                  nvc [QW+1];
    rlu_pkg::norm_side_t   nsc [QW+1];
    logic [1:0][AW-1:0]    nnc [QW+1];
    logic [1:0][DW-1:0]    ndc [QW+1];
    logic [1:0][DW-1:0]    nrc [QW+1];
    logic [1:0][QW-1:0]    nqc [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nvc[0] <= 1'b0;
        else if (en)
            nvc[0] <= point.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nsc[0] <= nside_next;
            nnc[0] <= nnum_next;
            ndc[0] <= nden_next;
            nrc[0] <= nrem_next;
        end
    end

    assign nqc[0] = '0;

    for (genvar k = 0; k < QW; k++)
    begin : g_norm
        rlu_div_cell #(
            .DW(DW), .AW(AW), .QW(QW), .BIT(QW - 1 - k), .side_t(rlu_pkg::norm_side_t)
        ) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_i(nvc[k]), .side_i(nsc[k]), .num_i(nnc[k]), .den_i(ndc[k]),
            .rem_i(nrc[k]), .quo_i(nqc[k]),
            .valid_o(nvc[k+1]), .side_o(nsc[k+1]), .num_o(nnc[k+1]), .den_o(ndc[k+1]),
            .rem_o(nrc[k+1]), .quo_o(nqc[k+1])
        );
    end

    // ---------------------------------------------------------------
    // Iteration chain; x and y start at the normalized values
    // ---------------------------------------------------------------
    logic                 iv [ITERATIONS+1];
    rlu_pkg::iter_state_t ist [ITERATIONS+1];
    rlu_pkg::iter_state_t ist0_next;

    always_comb
    begin
        rlu_pkg::norm_side_t s;
        s = nsc[QW];
        ist0_next.xn    = rlu_pkg::div_sat(nqc[QW][0], s.ovf[0], s.neg[0], s.zero[0]);
        ist0_next.yn    = rlu_pkg::div_sat(nqc[QW][1], s.ovf[1], s.neg[1], s.zero[1]);
        ist0_next.x     = ist0_next.xn;
        ist0_next.y     = ist0_next.yn;
        ist0_next.degen = 1'b0;
        ist0_next.last  = s.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iv[0] <= 1'b0;
        else if (en)
            iv[0] <= nvc[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ist[0] <= ist0_next;
    end

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_iter
        rlu_iter u_iter (
            .clk(clk), .rst_n(rst_n), .en(en),
            .k1(k1_reg), .k2(k2_reg),
            .valid_i(iv[i]), .st_i(ist[i]),
            .valid_o(iv[i+1]), .st_o(ist[i+1])
        );
    end

    // ---------------------------------------------------------------
    // Back-projection: focal * x rounded to Q8, plus center, saturated
    // ---------------------------------------------------------------
    logic               pv_reg;
    logic signed [43:0] pu_reg, pw_reg;
    logic               pdeg_reg, plast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (en)
            pv_reg <= iv[ITERATIONS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg    <= $signed({1'b0, focal_x_reg}) * ist[ITERATIONS].x;
            pw_reg    <= $signed({1'b0, focal_y_reg}) * ist[ITERATIONS].y;
            pdeg_reg  <= ist[ITERATIONS].degen;
            plast_reg <= ist[ITERATIONS].last;
        end
    end

    function automatic rlu_pkg::pix_t project(logic signed [43:0] p, logic [19:0] c);
        logic [43:0]        m;
        logic [25:0]        a;
        logic signed [25:0] s;
        rlu_pkg::pix_t      r;
        m = p[43] ? 44'(-p) : 44'(p);
        a = 26'((m + 44'd524288) >> 20);
        s = (p[43] ? -$signed(a) : $signed(a)) + $signed({6'b0, c});
        if (s > 26'sd8388607)
            r = 24'sh7FFFFF;
        else if (s < -26'sd8388608)
            r = 24'sh800000;
        else
            r = s[23:0];
        return r;
    endfunction

    rlu_pkg::pix_t und_u_reg, und_v_reg;
    logic          deg_reg, last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= pv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            und_u_reg <= project(pu_reg, center_x_reg);
            und_v_reg <= project(pw_reg, center_y_reg);
            deg_reg   <= pdeg_reg;
            last_reg  <= plast_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.und_u      = und_u_reg;
    assign result.und_v      = und_v_reg;
    assign result.degenerate = deg_reg;
    assign result.last_out   = last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // With no distortion the radial factor is exactly one and never degenerate.
    a_no_degen_without_k: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && k1_reg == 20'sd0 && k2_reg == 20'sd0) |-> !result.degenerate)
        else $error("degenerate flagged with zero distortion coefficients");

    // A held output freezes the stage feeding it.
    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> $stable(pv_reg))
        else $error("pipeline advanced while the output was stalled");

    // Input is refused exactly while the output request waits.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |-> !point.ready)
        else $error("input accepted while the output was stalled");

endmodule
